>>> rtl/core/mrr_pkg.sv
// Shared types and constants for the Miller-Rabin round block.
// No dependencies; imported by mrr_mulmod and miller_rabin_round.
package mrr_pkg;

  localparam int IN_W      = 32;  // width of the input item fields
  localparam int VERDICT_W = 2;

  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_COMPOSITE = 2'd0;
  localparam verdict_t VERDICT_PRIME     = 2'd1;
  localparam verdict_t VERDICT_INVALID   = 2'd2;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid alongside
  } mm_status_t;

endpackage

>>> rtl/core/mrr_mulmod.sv
// Shared modular multiplier: (x * y) mod n by MSB-first double-and-add.
// Depends on mrr_pkg (status struct).
module mrr_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [WIDTH-1:0]       x,
  input  logic [WIDTH-1:0]       y,
  input  logic [WIDTH-1:0]       n,
  output logic [WIDTH-1:0]       res,
  output mrr_pkg::mm_status_t    status
);
  import mrr_pkg::*;

  localparam int CW = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             phase_r, phase_nxt;   // 0: double, 1: add x
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;

  logic [WIDTH-1:0] op_b;
  logic [WIDTH-1:0] room;
  logic             wrap;
  logic [WIDTH-1:0] sum;

  // one modular add, both operands below n: no overflow
  assign op_b = phase_r ? x_r : acc_r;
  assign room = n_r - op_b;
  assign wrap = (acc_r >= room);
  assign sum  = wrap ? (acc_r - room) : (acc_r + op_b);

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    n_nxt     = n_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CW'(WIDTH - 1);
      acc_nxt   = '0;
      x_nxt     = x;
      y_nxt     = y;
      n_nxt     = n;
    end else if (busy_r) begin
      acc_nxt = sum;
      if (!phase_r && y_r[WIDTH-1]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        y_nxt     = y_r << 1;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
  end

  assign res         = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/core/miller_rabin_round.sv
// Miller-Rabin round: top level sequencer around the shared modular multiplier.
// Depends on mrr_pkg and mrr_mulmod.
//
// One item (n, a) gives one verdict: composite, probable prime for this
// witness, or invalid when n is below two. Only the low WIDTH bits of each
// field are used. The block handles one item at a time: in_stall is high from
// acceptance until the verdict has been loaded into the output register, and
// a verdict may sit there waiting on out_stall while the next item is taken.
// All arithmetic runs through one modular multiplier that does a bit of the
// multiplier operand per cycle, plus an extra add step for each set bit. A
// round needs one product to reduce the witness mod n, at most two per bit
// of the odd part m of n-1 for the power, and at most k squarings
// afterwards, which is under 2*WIDTH+1 products. Splitting n-1 into 2^k * m
// strips its trailing zeros one at a time. An n below two skips the
// arithmetic and goes straight to the hand-off state.
module miller_rabin_round #(
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mrr_pkg::IN_W-1:0]      in_number_under_test,
  input  logic [mrr_pkg::IN_W-1:0]      in_witness,
  // verdict out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mrr_pkg::VERDICT_W-1:0] out_verdict
);
  import mrr_pkg::*;

  localparam int KW = $clog2(WIDTH);

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SPLIT   = 4'd1;  // strip trailing zeros of n-1
  localparam logic [3:0] S_REDUCE  = 4'd2;  // a mod n, as 1*a mod n
  localparam logic [3:0] S_POW     = 4'd3;  // pick next step of a^m
  localparam logic [3:0] S_POW_MUL = 4'd4;  // acc *= base
  localparam logic [3:0] S_POW_SQ  = 4'd5;  // base *= base
  localparam logic [3:0] S_CHK1    = 4'd6;  // b == 1 ?
  localparam logic [3:0] S_LOOP    = 4'd7;  // k == 0 ? composite, else b == n-1 ? else square
  localparam logic [3:0] S_LOOP_SQ = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;  // hand verdict to output reg

  localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [3:0]       state_r, state_nxt;
  logic [WIDTH-1:0] nm1_r, nm1_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic             out_valid_r, out_valid_nxt;
  verdict_t         out_verdict_r, out_verdict_nxt;

  logic [WIDTH-1:0] n_in;
  logic [WIDTH-1:0] a_in;
  logic             in_acc;

  logic             mm_start;
  logic [WIDTH-1:0] mm_x;
  logic [WIDTH-1:0] mm_y;
  logic [WIDTH-1:0] mm_res;
  mm_status_t       mm_st;

  // low WIDTH bits of the fields, zero-extended where WIDTH is wider
  generate
    if (WIDTH <= IN_W) begin : g_narrow
      assign n_in = in_number_under_test[WIDTH-1:0];
      assign a_in = in_witness[WIDTH-1:0];
    end else begin : g_wide
      assign n_in = {{(WIDTH-IN_W){1'b0}}, in_number_under_test};
      assign a_in = {{(WIDTH-IN_W){1'b0}}, in_witness};
    end
  endgenerate

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  mrr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .n      (n_r),
    .res    (mm_res),
    .status (mm_st)
  );

  always_comb begin
    state_nxt       = state_r;
    nm1_nxt         = nm1_r;
    n_nxt           = n_r;
    a_nxt           = a_r;
    m_nxt           = m_r;
    k_nxt           = k_r;
    base_nxt        = base_r;
    acc_nxt         = acc_r;
    verdict_nxt     = verdict_r;
    out_verdict_nxt = out_verdict_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mm_start        = 1'b0;
    mm_x            = '0;
    mm_y            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          n_nxt   = n_in;
          nm1_nxt = n_in - 1'b1;
          m_nxt   = n_in - 1'b1;
          a_nxt   = a_in;
          k_nxt   = '0;
          if (n_in[WIDTH-1:1] == '0) begin
            verdict_nxt = VERDICT_INVALID;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        // n >= 2, so m is non-zero and this ends
        if (!m_r[0]) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          mm_start  = 1'b1;
          mm_x      = ONE;
          mm_y      = a_r;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mm_st.done) begin
          base_nxt  = mm_res;
          acc_nxt   = ONE;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        if (m_r == '0) begin
          state_nxt = S_CHK1;
        end else if (m_r[0]) begin
          mm_start  = 1'b1;
          mm_x      = acc_r;
          mm_y      = base_r;
          state_nxt = S_POW_MUL;
        end else begin
          mm_start  = 1'b1;
          mm_x      = base_r;
          mm_y      = base_r;
          state_nxt = S_POW_SQ;
        end
      end
      S_POW_MUL: begin
        if (mm_st.done) begin
          acc_nxt = mm_res;
          if (m_r[WIDTH-1:1] == '0) begin
            // last exponent bit: the closing square is not needed
            m_nxt     = '0;
            state_nxt = S_CHK1;
          end else begin
            mm_start  = 1'b1;
            mm_x      = base_r;
            mm_y      = base_r;
            state_nxt = S_POW_SQ;
          end
        end
      end
      S_POW_SQ: begin
        if (mm_st.done) begin
          base_nxt  = mm_res;
          m_nxt     = m_r >> 1;
          state_nxt = S_POW;
        end
      end
      S_CHK1: begin
        if (acc_r == ONE) begin
          verdict_nxt = VERDICT_PRIME;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (k_r == '0) begin
          verdict_nxt = VERDICT_COMPOSITE;
          state_nxt   = S_FIN;
        end else if (acc_r == nm1_r) begin
          verdict_nxt = VERDICT_PRIME;
          state_nxt   = S_FIN;
        end else begin
          mm_start  = 1'b1;
          mm_x      = acc_r;
          mm_y      = acc_r;
          state_nxt = S_LOOP_SQ;
        end
      end
      S_LOOP_SQ: begin
        if (mm_st.done) begin
          acc_nxt   = mm_res;
          k_nxt     = k_r - 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_FIN: begin
        // output register free, or emptied this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    nm1_r         <= nm1_nxt;
    a_r           <= a_nxt;
    m_r           <= m_nxt;
    k_r           <= k_nxt;
    base_r        <= base_nxt;
    acc_r         <= acc_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

`ifndef ASSERT_OFF
  // the multiplier is never restarted mid-product
  a_mm_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_st.busy)
    else $error("multiplier started while busy");

  // a product only completes after the unit was busy
  a_mm_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_st.done |-> $past(mm_st.busy))
    else $error("multiplier done without being busy");

  // a verdict only appears out of the hand-off state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("verdict issued outside hand-off");
`endif

endmodule
